@@ sv/gbn_pkg.sv @@
// Shared constants, types and helpers for the go-back-n sender.
package gbn_pkg;

   localparam int SEQ_W        = 16;
   localparam int PAYLOAD_W    = 64;
   localparam int CMD_W        = 2;
   localparam int TIMER_W      = 2;
   localparam int LIMIT_W      = 6;
   localparam int BUFFER_DEPTH = 64;
   localparam int WINDOW_MAX   = 32;
   localparam int RING_DEPTH   = 128;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int QCNT_W       = $clog2(BUFFER_DEPTH + 1);
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   typedef logic [SEQ_W-1:0]     seq_type;
   typedef logic [PAYLOAD_W-1:0] payload_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [TIMER_W-1:0]   timer_type;
   typedef logic [LIMIT_W-1:0]   limit_type;
   typedef logic [RING_AW-1:0]   slot_type;
   typedef logic [QCNT_W-1:0]    qcnt_type;

   localparam cmd_type CMD_SEND    = 2'd0;
   localparam cmd_type CMD_ACK     = 2'd1;
   localparam cmd_type CMD_TIMEOUT = 2'd2;
   localparam cmd_type CMD_NONE    = 2'd3;

   localparam timer_type TIMER_NONE    = 2'd0;
   localparam timer_type TIMER_START   = 2'd1;
   localparam timer_type TIMER_STOP    = 2'd2;
   localparam timer_type TIMER_RESTART = 2'd3;

   localparam logic [CSR_AW-1:0] ADDR_WINDOW_LIMIT = 3'd0;

   localparam limit_type LIMIT_RESET = 6'd8;
   localparam seq_type   SEQ_RESET   = 16'd1;

   // Clamp the programmed window into 1..WINDOW_MAX.
   function automatic limit_type eff_window(input limit_type limit);
      limit_type w;
      w = limit;
      if (limit == '0) begin
         w = limit_type'(1);
      end else if (limit > limit_type'(WINDOW_MAX)) begin
         w = limit_type'(WINDOW_MAX);
      end
      return w;
   endfunction

endpackage

@@ sv/gbn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gbn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/go_back_n_sender.sv @@
// Go-back-n sender: window control, payload ring in RAM, one registered result at a time.
// A send with an empty queue and an open window passes the decide, loop and closing
// states; once the output is free, the closing state writes the payload to the ring
// and registers its packet. Requests are taken only in idle; the ring has one read port.
// Reset (synchronous): base and next sequence 1, queue empty, timer idle, window 8.
// The ring is not cleared; only entries already written are ever read.
module go_back_n_sender (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gbn_pkg::cmd_type         req_command,
   input  gbn_pkg::payload_type     req_payload_word,
   input  gbn_pkg::seq_type         req_ack_number,
   input  logic                     req_ack_corrupt,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_has_packet,
   output gbn_pkg::seq_type         rsp_packet_seq,
   output gbn_pkg::payload_type     rsp_packet_payload,
   output gbn_pkg::timer_type       rsp_timer_action,
   output logic                     rsp_message_dropped,
   output logic                     rsp_last_result,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [gbn_pkg::CSR_AW-1:0] paddr,
   input  logic [gbn_pkg::CSR_DW-1:0] pwdata,
   output logic [gbn_pkg::CSR_DW-1:0] prdata,
   output logic                     pready
);

   import gbn_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_LOOP   = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   logic [2:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   payload_type payload_ff, payload_in;
   seq_type     ack_ff, ack_in;
   logic        corrupt_ff, corrupt_in;
   seq_type     base_ff, base_in;
   seq_type     next_ff, next_in;
   qcnt_type    queued_ff, queued_in;
   logic        running_ff, running_in;
   slot_type    base_slot_ff, base_slot_in;
   limit_type   idx_ff, idx_in;
   logic        final_ff, final_in;
   limit_type   limit_ff, limit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_has_ff, rsp_has_in;
   seq_type     rsp_seq_ff, rsp_seq_in;
   payload_type rsp_pay_ff, rsp_pay_in;
   timer_type   rsp_timer_ff, rsp_timer_in;
   logic        rsp_drop_ff, rsp_drop_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        ram_wr_en;
   slot_type    ram_wr_addr;
   payload_type ram_wr_data;
   logic        ram_rd_en;
   slot_type    ram_rd_addr;
   payload_type ram_rd_data;

   limit_type   win;
   seq_type     flight_wide;
   limit_type   flight;
   seq_type     ack_dist;
   slot_type    next_slot;
   slot_type    queue_slot;
   slot_type    resend_slot;
   logic        out_free;
   logic        emit;
   logic        is_final;
   logic        csr_write;

   // Reads and writes of the ring never overlap: reads happen in the drain or
   // resend loop, the single write only in the closing step of a send.
   gbn_ram #(
      .WIDTH(PAYLOAD_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign win         = eff_window(limit_ff);
   assign flight_wide = next_ff - base_ff;
   assign flight      = flight_wide[LIMIT_W-1:0];
   assign ack_dist    = ack_ff - base_ff;
   assign next_slot   = base_slot_ff + slot_type'(flight);
   assign queue_slot  = next_slot + slot_type'(queued_ff);
   assign resend_slot = base_slot_ff + slot_type'(idx_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign csr_write   = psel && penable && pwrite && pready;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      payload_in   = payload_ff;
      ack_in       = ack_ff;
      corrupt_in   = corrupt_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      queued_in    = queued_ff;
      running_in   = running_ff;
      base_slot_in = base_slot_ff;
      idx_in       = idx_ff;
      final_in     = final_ff;
      limit_in     = limit_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = next_slot;
      ram_wr_data  = payload_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = next_slot;

      emit         = 1'b0;
      is_final     = 1'b0;
      rsp_has_in   = 1'b0;
      rsp_seq_in   = '0;
      rsp_pay_in   = '0;
      rsp_timer_in = TIMER_NONE;
      rsp_drop_in  = 1'b0;
      rsp_last_in  = 1'b0;

      if (csr_write && paddr == ADDR_WINDOW_LIMIT) begin
         limit_in = pwdata[LIMIT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_command;
               payload_in = req_payload_word;
               ack_in     = req_ack_number;
               corrupt_in = req_ack_corrupt;
               idx_in     = '0;
               final_in   = 1'b0;
               state_in   = S_DECIDE;
            end
         end

         S_DECIDE: begin
            unique case (cmd_ff)
               CMD_ACK: begin
                  if (corrupt_ff || ack_dist >= seq_type'(flight)) begin
                     // drop stale, out-of-range or corrupt acks
                     cmd_in   = CMD_NONE;
                     state_in = S_FIN;
                  end else begin
                     base_slot_in = base_slot_ff + ack_dist[RING_AW-1:0] + slot_type'(1);
                     base_in      = ack_ff + seq_type'(1);
                     state_in     = S_LOOP;
                  end
               end
               CMD_SEND, CMD_TIMEOUT: begin
                  state_in = S_LOOP;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end

         S_LOOP: begin
            if (cmd_ff == CMD_TIMEOUT) begin
               if (idx_ff < flight) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = resend_slot;
                  state_in    = S_EMIT;
               end else begin
                  state_in = S_FIN;
               end
            end else if (flight < win && queued_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_slot;
               state_in    = S_EMIT;
            end else begin
               state_in = S_FIN;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               emit       = 1'b1;
               rsp_has_in = 1'b1;
               rsp_pay_in = ram_rd_data;
               if (cmd_ff == CMD_TIMEOUT) begin
                  rsp_seq_in = base_ff + seq_type'(idx_ff);
                  is_final   = (idx_ff == flight - limit_type'(1));
                  idx_in     = idx_ff + limit_type'(1);
                  if (is_final) begin
                     rsp_timer_in = running_ff ? TIMER_RESTART : TIMER_START;
                     running_in   = 1'b1;
                  end
               end else begin
                  rsp_seq_in = next_ff;
                  next_in    = next_ff + seq_type'(1);
                  queued_in  = queued_ff - qcnt_type'(1);
                  if (cmd_ff == CMD_SEND) begin
                     // the new payload goes out only if this drain empties the
                     // queue with room to spare
                     is_final = (flight >= win - limit_type'(1));
                     if (is_final) begin
                        rsp_timer_in = running_ff ? TIMER_NONE : TIMER_START;
                        running_in   = 1'b1;
                     end
                  end else begin
                     is_final = (queued_ff == qcnt_type'(1)) ||
                                (flight >= win - limit_type'(1));
                     if (is_final) begin
                        rsp_timer_in = running_ff ? TIMER_RESTART : TIMER_START;
                        running_in   = 1'b1;
                     end
                  end
               end
               rsp_last_in = is_final;
               final_in    = is_final;
               if (!is_final) begin
                  state_in = S_LOOP;
               end else if (cmd_ff == CMD_SEND) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               state_in    = S_IDLE;
               rsp_last_in = 1'b1;
               unique case (cmd_ff)
                  CMD_SEND: begin
                     if (queued_ff == '0 && flight < win) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = next_slot;
                        emit         = 1'b1;
                        rsp_has_in   = 1'b1;
                        rsp_seq_in   = next_ff;
                        rsp_pay_in   = payload_ff;
                        rsp_timer_in = running_ff ? TIMER_NONE : TIMER_START;
                        running_in   = 1'b1;
                        next_in      = next_ff + seq_type'(1);
                     end else begin
                        if (queued_ff < qcnt_type'(BUFFER_DEPTH)) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = queue_slot;
                           queued_in   = queued_ff + qcnt_type'(1);
                        end else begin
                           rsp_drop_in = 1'b1;
                        end
                        emit = !final_ff;
                     end
                  end
                  CMD_ACK: begin
                     emit = 1'b1;
                     if (base_ff == next_ff) begin
                        rsp_timer_in = running_ff ? TIMER_STOP : TIMER_NONE;
                        running_in   = 1'b0;
                     end else begin
                        rsp_timer_in = running_ff ? TIMER_RESTART : TIMER_START;
                        running_in   = 1'b1;
                     end
                  end
                  CMD_TIMEOUT: begin
                     emit         = 1'b1;
                     rsp_timer_in = running_ff ? TIMER_RESTART : TIMER_START;
                     running_in   = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold a waiting result until taken; load a new one when emitting
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= SEQ_RESET;
         next_ff      <= SEQ_RESET;
         queued_ff    <= '0;
         running_ff   <= 1'b0;
         base_slot_ff <= '0;
         idx_ff       <= '0;
         final_ff     <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_NONE;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         queued_ff    <= queued_in;
         running_ff   <= running_in;
         base_slot_ff <= base_slot_in;
         idx_ff       <= idx_in;
         final_ff     <= final_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      ack_ff     <= ack_in;
      corrupt_ff <= corrupt_in;
      if (emit) begin
         rsp_has_ff   <= rsp_has_in;
         rsp_seq_ff   <= rsp_seq_in;
         rsp_pay_ff   <= rsp_pay_in;
         rsp_timer_ff <= rsp_timer_in;
         rsp_drop_ff  <= rsp_drop_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_has_packet      = rsp_has_ff;
   assign rsp_packet_seq      = rsp_seq_ff;
   assign rsp_packet_payload  = rsp_pay_ff;
   assign rsp_timer_action    = rsp_timer_ff;
   assign rsp_message_dropped = rsp_drop_ff;
   assign rsp_last_result     = rsp_last_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_WINDOW_LIMIT) ? CSR_DW'(limit_ff) : '0;

endmodule
